// ----- sv/amfc_pkg.sv -----
// Shared types, codes, constants and the CRC-16 step for the attitude frame checker.
package amfc_pkg;

    // Frame layout
    localparam int POS_W          = 5;
    localparam logic [POS_W-1:0] FRAME_LEN    = 5'd23;
    localparam logic [POS_W-1:0] FRAME_OVER   = 5'd24;
    localparam logic [POS_W-1:0] CRC_END      = 5'd21;
    localparam logic [POS_W-1:0] POS_ADDR     = 5'd0;
    localparam logic [POS_W-1:0] POS_FUNC     = 5'd1;
    localparam logic [POS_W-1:0] POS_COUNT    = 5'd2;
    localparam logic [POS_W-1:0] GYRO_FIRST   = 5'd3;
    localparam logic [POS_W-1:0] GYRO_LAST    = 5'd8;
    localparam logic [POS_W-1:0] ANG_FIRST    = 5'd15;
    localparam logic [POS_W-1:0] ANG_LAST     = 5'd20;
    localparam logic [POS_W-1:0] CHK_LO_POS   = 5'd21;
    localparam logic [POS_W-1:0] CHK_HI_POS   = 5'd22;

    localparam logic [7:0]  READ_FUNC  = 8'h03;
    localparam logic [7:0]  DATA_COUNT = 8'd18;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam int NUM_WORDS  = 6;
    localparam int WORD_IDX_W = 3;
    localparam logic [WORD_IDX_W-1:0] NUM_GYRO = 3'd3;
    localparam int W_ROLL  = 3;
    localparam int W_PITCH = 4;
    localparam int W_YAW   = 5;

    // Arithmetic widths
    localparam int ANG_PROD_W  = 25;
    localparam int GYRO_PROD_W = 29;
    localparam int YAW_SUM_W   = 26;
    localparam int FULL_TURN_Q15 = 11796480;

    localparam int AGE_WIDTH_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    // Reset values of the configuration registers
    localparam logic [7:0]  DEV_ADDR_RST   = 8'd96;
    localparam logic [7:0]  ANG_RANGE_RST  = 8'd180;
    localparam logic [11:0] GYRO_RANGE_RST = 12'd2000;
    localparam logic [23:0] DECL_RST       = 24'd0;
    localparam logic [7:0]  HDR_LIMIT_RST  = 8'd3;
    localparam logic [15:0] STALE_RST      = 16'd500;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_EOF  = 3'd1,
        KIND_TXF  = 3'd2,
        KIND_RXF  = 3'd3,
        KIND_TICK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TX      = 3'd1,
        ST_RX      = 3'd2,
        ST_LEN     = 3'd3,
        ST_HDR     = 3'd4,
        ST_CRC     = 3'd5,
        ST_TIMEOUT = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR   = 3'd0,
        CFG_ANG_RANGE  = 3'd1,
        CFG_GYRO_RANGE = 3'd2,
        CFG_DECL       = 3'd3,
        CFG_HDR_LIMIT  = 3'd4,
        CFG_STALE      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]         device_address;
        logic [7:0]         angle_range;
        logic [11:0]        gyro_range;
        logic signed [23:0] declination;
        logic [7:0]         header_fail_limit;
        logic [15:0]        stale_limit_ms;
    } cfg_t;

    // Resolved frame result, words as they stand after the frame
    typedef struct packed {
        status_t                     status;
        logic [7:0]                  fail_cnt;
        logic [NUM_WORDS-1:0][15:0]  words;
    } res_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         fail_cnt;
        logic signed [23:0] roll;
        logic signed [23:0] pitch;
        logic signed [23:0] yaw_prod;
        logic signed [27:0] rate_x;
        logic signed [27:0] rate_y;
        logic signed [27:0] rate_z;
    } prod_t;

    // First member lands in the highest bits
    typedef struct packed {
        logic [27:0] rate_z;
        logic [27:0] rate_y;
        logic [27:0] rate_x;
        logic [23:0] yaw;
        logic [23:0] pitch;
        logic [23:0] roll;
        logic [7:0]  fail_cnt;
        status_t     status;
    } out_t;

    localparam int OUT_W   = $bits(out_t);
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    // One byte of CRC-16/Modbus, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/amfc_parser.sv -----
// Byte parser, CRC check, frame resolution and health counters.
module amfc_parser
    import amfc_pkg::*;
#(
    parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [2:0] kind,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    input  logic       res_take,
    output logic       res_ready,
    output logic       res_vld,
    output res_t       res
);

    localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [15:0]                    crc_reg, crc_next;
    logic                           hdr_good_reg, hdr_good_next;
    logic [15:0]                    chk_reg, chk_next;
    logic [NUM_WORDS-1:0][15:0]     pend_reg, pend_next;
    logic [NUM_WORDS-1:0][15:0]     held_reg, held_next;
    logic [7:0]                     fail_reg, fail_next;
    logic [AGE_WIDTH-1:0]           age_reg, age_next;
    logic                           res_vld_reg, res_vld_next;
    res_t                           res_reg, res_next;

    logic                           is_res;
    logic                           stale;
    logic [7:0]                     fail_inc;
    status_t                        base_st;
    status_t                        fin_st;
    logic [POS_W-1:0]               gyro_off, ang_off;
    logic                           in_gyro, in_ang;
    logic [WORD_IDX_W-1:0]          word_idx;

    assign is_res = (kind == KIND_EOF) || (kind == KIND_TXF) || (kind == KIND_RXF);
    assign stale  = CMP_W'(age_reg) > CMP_W'(cfg.stale_limit_ms);
    assign fail_inc = (fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1;

    assign gyro_off = pos_reg - GYRO_FIRST;
    assign ang_off  = pos_reg - ANG_FIRST;
    assign in_gyro  = (pos_reg >= GYRO_FIRST) && (pos_reg <= GYRO_LAST);
    assign in_ang   = (pos_reg >= ANG_FIRST) && (pos_reg <= ANG_LAST);
    assign word_idx = in_gyro ? gyro_off[3:1] : NUM_GYRO + ang_off[3:1];

    // Checks in order: tx failure, rx failure, length, header, CRC
    always_comb begin
        if (kind == KIND_TXF) begin
            base_st = ST_TX;
        end else if (kind == KIND_RXF) begin
            base_st = ST_RX;
        end else if (pos_reg != FRAME_LEN) begin
            base_st = ST_LEN;
        end else if (!hdr_good_reg) begin
            base_st = ST_HDR;
        end else if (crc_reg != chk_reg) begin
            base_st = ST_CRC;
        end else begin
            base_st = ST_OK;
        end
    end

    always_comb begin
        case (base_st)
            ST_OK:   fin_st = ST_OK;
            ST_HDR:  fin_st = (fail_inc > cfg.header_fail_limit) ? ST_HDR :
                              (stale ? ST_TIMEOUT : ST_HDR);
            default: fin_st = stale ? ST_TIMEOUT : base_st;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_good_next = hdr_good_reg;
        chk_next      = chk_reg;
        pend_next     = pend_reg;
        held_next     = held_reg;
        fail_next     = fail_reg;
        age_next      = age_reg;
        res_next      = res_reg;
        res_vld_next  = res_vld_reg && !res_take;

        if (step) begin
            case (kind)
                KIND_BYTE: begin
                    if (pos_reg >= FRAME_LEN) begin
                        pos_next = FRAME_OVER;
                    end else begin
                        if (pos_reg < CRC_END) begin
                            crc_next = crc_byte(crc_reg, rx_byte);
                        end
                        if ((pos_reg == POS_ADDR && rx_byte != cfg.device_address) ||
                            (pos_reg == POS_FUNC && rx_byte != READ_FUNC) ||
                            (pos_reg == POS_COUNT && rx_byte != DATA_COUNT)) begin
                            hdr_good_next = 1'b0;
                        end
                        if (in_gyro || in_ang) begin
                            if (pos_reg[0]) begin
                                pend_next[word_idx][15:8] = rx_byte;
                            end else begin
                                pend_next[word_idx][7:0] = rx_byte;
                            end
                        end else if (pos_reg == CHK_LO_POS) begin
                            chk_next[7:0] = rx_byte;
                        end else if (pos_reg == CHK_HI_POS) begin
                            chk_next[15:8] = rx_byte;
                        end
                        pos_next = pos_reg + 5'd1;
                    end
                end
                KIND_TICK: begin
                    if (age_reg != '1) begin
                        age_next = age_reg + AGE_WIDTH'(1);
                    end
                end
                KIND_EOF, KIND_TXF, KIND_RXF: begin
                    // End the frame and start the next one clean
                    pos_next      = '0;
                    crc_next      = CRC_INIT;
                    hdr_good_next = 1'b1;
                    chk_next      = '0;
                    if (base_st == ST_OK) begin
                        held_next = pend_reg;
                        fail_next = '0;
                        age_next  = '0;
                    end else if (base_st == ST_HDR) begin
                        fail_next = fail_inc;
                    end
                    res_next.status   = fin_st;
                    res_next.fail_cnt = fail_next;
                    res_next.words    = (base_st == ST_OK) ? pend_reg : held_reg;
                    res_vld_next      = is_res;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            hdr_good_reg <= 1'b1;
            chk_reg      <= '0;
            held_reg     <= '0;
            fail_reg     <= '0;
            age_reg      <= '0;
            res_vld_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_good_reg <= hdr_good_next;
            chk_reg      <= chk_next;
            held_reg     <= held_next;
            fail_reg     <= fail_next;
            age_reg      <= age_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_ready = !res_vld_reg || res_take;
    assign res_vld   = res_vld_reg;
    assign res       = res_reg;

endmodule

// ----- sv/amfc_scaler.sv -----
// Q15 scaling of the held words, yaw wrap and the product and output registers.
module amfc_scaler
    import amfc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic res_vld,
    input  res_t res,
    input  cfg_t cfg,
    output logic res_take,
    input  logic out_ready,
    output logic out_vld,
    output out_t out
);

    localparam logic signed [YAW_SUM_W-1:0] TURN   = YAW_SUM_W'(FULL_TURN_Q15);
    localparam logic signed [YAW_SUM_W-1:0] TURN2  = YAW_SUM_W'(2 * FULL_TURN_Q15);
    localparam logic signed [YAW_SUM_W-1:0] NTURN  = -TURN;

    logic  prod_vld_reg, prod_vld_next;
    prod_t prod_reg, prod_next;
    logic  out_vld_reg, out_vld_next;
    out_t  out_reg, out_next;
    logic  out_adv;

    logic signed [ANG_PROD_W-1:0]  mul_roll, mul_pitch, mul_yaw;
    logic signed [GYRO_PROD_W-1:0] mul_x, mul_y, mul_z;
    logic signed [YAW_SUM_W-1:0]   ysum, ywrap;

    assign out_adv  = !out_vld_reg || out_ready;
    assign res_take = !prod_vld_reg || out_adv;

    assign mul_roll  = $signed(res.words[W_ROLL])  * $signed({1'b0, cfg.angle_range});
    assign mul_pitch = $signed(res.words[W_PITCH]) * $signed({1'b0, cfg.angle_range});
    assign mul_yaw   = $signed(res.words[W_YAW])   * $signed({1'b0, cfg.angle_range});
    assign mul_x     = $signed(res.words[0]) * $signed({1'b0, cfg.gyro_range});
    assign mul_y     = $signed(res.words[1]) * $signed({1'b0, cfg.gyro_range});
    assign mul_z     = $signed(res.words[2]) * $signed({1'b0, cfg.gyro_range});

    always_comb begin
        prod_next          = prod_reg;
        prod_next.status   = res.status;
        prod_next.fail_cnt = res.fail_cnt;
        prod_next.roll     = mul_roll[23:0];
        prod_next.pitch    = mul_pitch[23:0];
        prod_next.yaw_prod = mul_yaw[23:0];
        prod_next.rate_x   = mul_x[27:0];
        prod_next.rate_y   = mul_y[27:0];
        prod_next.rate_z   = mul_z[27:0];
    end

    // Heading is clockwise: negate, add declination, fold into one turn
    assign ysum = $signed(cfg.declination) - $signed(prod_reg.yaw_prod);

    always_comb begin
        if (ysum < NTURN) begin
            ywrap = ysum + TURN2;
        end else if (ysum < 0) begin
            ywrap = ysum + TURN;
        end else if (ysum >= TURN) begin
            ywrap = ysum - TURN;
        end else begin
            ywrap = ysum;
        end
    end

    always_comb begin
        out_next.status   = prod_reg.status;
        out_next.fail_cnt = prod_reg.fail_cnt;
        out_next.roll     = prod_reg.roll;
        out_next.pitch    = prod_reg.pitch;
        out_next.yaw      = ywrap[23:0];
        out_next.rate_x   = prod_reg.rate_x;
        out_next.rate_y   = prod_reg.rate_y;
        out_next.rate_z   = prod_reg.rate_z;
    end

    assign prod_vld_next = (prod_vld_reg && !out_adv) || (res_vld && res_take);
    assign out_vld_next  = (out_vld_reg && !out_ready) || (prod_vld_reg && out_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_vld && res_take) begin
            prod_reg <= prod_next;
        end
        if (prod_vld_reg && out_adv) begin
            out_reg <= out_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign out     = out_reg;

endmodule

// ----- sv/modbus_attitude_frame_checker_top.sv -----
// Top level of the Modbus RTU attitude response checker: ports, config, input stage.
// A frame-ending request (end of frame, tx or rx failure) reaches m_tdata through the
//   input, parser result, product and output registers; bytes, ticks, unused kinds: none.
// Throughput: one request per cycle unless stalled; a byte's CRC step and capture are registered.
// Stalls: the input stage holds only when a result request meets a full result pipe.
// Reset: aresetn is synchronous, active low; it loads the register defaults, clears
//   the frame state, counters, age and held words, and empties the pipe at once.
module modbus_attitude_frame_checker_top
    import amfc_pkg::*;
#(
    parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [2:0]            s_tuser,   // [2:0] kind

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [10:3] header_fail_count, [34:11] roll, [58:35] pitch,
    // [82:59] yaw, [110:83] rate_x, [138:111] rate_y, [166:139] rate_z, [167] zero
    output logic [TDATA_W-1:0]    m_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    cfg_t cfg_reg, cfg_next;

    // Input stage: one request waits here while its state update is decided
    logic       in_vld_reg, in_vld_next;
    logic [2:0] in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       in_is_res;
    logic       in_adv;
    logic       s_accept;

    logic       par_res_ready;
    logic       res_vld;
    res_t       res;
    logic       res_take;
    out_t       out;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEV_ADDR:   cfg_next.device_address    = cfg_data[7:0];
                CFG_ANG_RANGE:  cfg_next.angle_range       = cfg_data[7:0];
                CFG_GYRO_RANGE: cfg_next.gyro_range        = cfg_data[11:0];
                CFG_DECL:       cfg_next.declination       = cfg_data[23:0];
                CFG_HDR_LIMIT:  cfg_next.header_fail_limit = cfg_data[7:0];
                CFG_STALE:      cfg_next.stale_limit_ms    = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address    <= DEV_ADDR_RST;
            cfg_reg.angle_range       <= ANG_RANGE_RST;
            cfg_reg.gyro_range        <= GYRO_RANGE_RST;
            cfg_reg.declination       <= DECL_RST;
            cfg_reg.header_fail_limit <= HDR_LIMIT_RST;
            cfg_reg.stale_limit_ms    <= STALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Bytes and ticks always advance; a result request advances only when the
    // result stage has room, so nothing is dropped or overwritten.
    assign in_is_res = (in_kind_reg == KIND_EOF) || (in_kind_reg == KIND_TXF) ||
                       (in_kind_reg == KIND_RXF);
    assign in_adv    = in_vld_reg && (!in_is_res || par_res_ready);
    assign s_tready  = !in_vld_reg || in_adv;
    assign s_accept  = s_tvalid && s_tready;
    assign in_vld_next = s_accept || (in_vld_reg && !in_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    // Capture the payload on every accepted request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    amfc_parser #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_adv),
        .kind      (in_kind_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_take  (res_take),
        .res_ready (par_res_ready),
        .res_vld   (res_vld),
        .res       (res)
    );

    amfc_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_vld   (res_vld),
        .res       (res),
        .cfg       (cfg_reg),
        .res_take  (res_take),
        .out_ready (m_tready),
        .out_vld   (m_tvalid),
        .out       (out)
    );

    // Pad the result to whole bytes with zeros on top
    assign m_tdata = {{(TDATA_W - OUT_W){1'b0}}, out};

`ifndef SYNTH
    // A good frame always clears the header failure count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out.status == ST_OK) |-> (out.fail_cnt == 8'd0))
        else $error("ok result with nonzero header failure count");

    // A header error is only reported after at least one counted failure
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out.status == ST_HDR) |-> (out.fail_cnt != 8'd0))
        else $error("header result with zero failure count");

    // Heading stays inside one full turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out.yaw < 24'd11796480))
        else $error("yaw outside 0..360 degrees");

    // A waiting input request must move once the result stage has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && par_res_ready) |=> (!in_vld_reg || !$stable(in_kind_reg) ||
                                           $past(s_accept)))
        else $error("input stage held with room downstream");
`endif

endmodule
